>>> design/lbsc_pkg.sv
// Shared constants, codes and types for the LRU bank slot cache.
package lbsc_pkg;

    localparam int NUM_SLOTS  = 8;
    localparam int SLOT_IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    localparam int MODE_W   = 2;
    localparam int BANK_W   = 8;
    localparam int BYTES_W  = 16;
    localparam int STAMP_W  = 32;
    localparam int SLOT_W   = 3;
    localparam int OFFSET_W = 23;
    localparam int PROD_W   = BANK_W + BYTES_W;

    localparam logic [BANK_W-1:0]   EMPTY_TAG        = 8'hFF;
    localparam logic [BYTES_W-1:0]  BANK_BYTES_RESET = 16'd8192;
    localparam logic [OFFSET_W-1:0] OFFSET_MAX       = 23'h7FFFFF;

    typedef enum logic [MODE_W-1:0] {
        MODE_LOOKUP = 2'd0,
        MODE_CLEAR  = 2'd1,
        MODE_QUERY  = 2'd2,
        MODE_UNUSED = 2'd3
    } mode_t;

    typedef logic [SLOT_IDX_W-1:0] slot_idx_t;

    // search token walking down the cell chain
    typedef struct packed {
        logic                 valid;
        logic [BANK_W-1:0]    bank;
        logic                 found;
        slot_idx_t            found_idx;
        logic                 min_valid;
        logic [STAMP_W-1:0]   min_stamp;
        slot_idx_t            min_idx;
    } pkt_t;

    // write broadcast to all cells
    typedef struct packed {
        logic                 clr;
        logic                 wr;
        slot_idx_t            idx;
        logic [BANK_W-1:0]    tag;
        logic [STAMP_W-1:0]   stamp;
    } upd_t;

endpackage

>>> design/lbsc_cell.sv
// One slot of the cache: holds tag and stamp, advances the search token by one cell.
module lbsc_cell (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  lbsc_pkg::slot_idx_t           cell_idx,
    input  lbsc_pkg::pkt_t                pkt_in,
    input  lbsc_pkg::upd_t                upd,
    output lbsc_pkg::pkt_t                pkt_out,
    output logic [lbsc_pkg::BANK_W-1:0]   tag
);
    import lbsc_pkg::*;

    logic [BANK_W-1:0]  tag_reg,   tag_next;
    logic [STAMP_W-1:0] stamp_reg, stamp_next;
    pkt_t               pkt_reg,   pkt_next;

    always_comb begin
        pkt_next = pkt_in;
        if (pkt_in.valid) begin
            if (!pkt_in.found && (tag_reg == pkt_in.bank)) begin
                pkt_next.found     = 1'b1;
                pkt_next.found_idx = cell_idx;
            end
            // strict less-than keeps the lowest index on ties
            if (!pkt_in.min_valid || (stamp_reg < pkt_in.min_stamp)) begin
                pkt_next.min_valid = 1'b1;
                pkt_next.min_stamp = stamp_reg;
                pkt_next.min_idx   = cell_idx;
            end
        end
    end

    always_comb begin
        tag_next   = tag_reg;
        stamp_next = stamp_reg;
        if (upd.clr) begin
            tag_next   = EMPTY_TAG;
            stamp_next = '0;
        end else if (upd.wr && (upd.idx == cell_idx)) begin
            tag_next   = upd.tag;
            stamp_next = upd.stamp;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_reg   <= EMPTY_TAG;
            stamp_reg <= '0;
            pkt_reg   <= '0;
        end else begin
            tag_reg   <= tag_next;
            stamp_reg <= stamp_next;
            pkt_reg   <= pkt_next;
        end
    end

    assign pkt_out = pkt_reg;
    assign tag     = tag_reg;

endmodule

>>> design/lru_bank_slot_cache.sv
// Top level of the LRU bank slot cache: control, cell chain and result register.
//
// Input channel s_*: one transaction per request (mode, bank_number, rom_kind,
// slot_query). Output channel m_*: exactly one result transaction per request.
// Config: cfg_wr_en/cfg_wr_data write the bank size at any idle clock edge.
// Lookup: the search token walks the NUM_SLOTS cells, one per cycle, then the
// chosen slot is retagged and stamped. Its result is registered in the
// control block first, then moved into the output register.
// Invalidate, query and the unused mode register their result at acceptance.
// One request is in flight at a time; s_ready rises again in the cycle the
// result is moved into the output register, so the next request overlaps a
// result still waiting for m_ready.
// A lookup holds off the next request while its token walks the cell chain,
// and any output stall holds off the next request too.
// Reset (aresetn low, synchronous): all tags empty (0xFF), stamps and tick
// zero, bank size 8192, no result pending.
// A stalled receiver holds the result in m_*; a further result waits in the
// control block and no new request is taken until the output register frees.
module lru_bank_slot_cache (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [lbsc_pkg::BYTES_W-1:0]       cfg_wr_data,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [lbsc_pkg::MODE_W-1:0]        s_mode,
    input  logic [lbsc_pkg::BANK_W-1:0]        s_bank_number,
    input  logic                               s_rom_kind,
    input  logic [lbsc_pkg::SLOT_W-1:0]        s_slot_query,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [lbsc_pkg::SLOT_W-1:0]        m_slot,
    output logic                               m_hit,
    output logic                               m_load_needed,
    output logic                               m_load_kind,
    output logic [lbsc_pkg::OFFSET_W-1:0]      m_load_offset,
    output logic [lbsc_pkg::BANK_W-1:0]        m_stored_bank
);
    import lbsc_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_RESULT
    } state_t;

    state_t              state_reg,       state_next;
    logic [STAMP_W-1:0]  tick_reg,        tick_next;
    logic [BYTES_W-1:0]  bank_bytes_reg,  bank_bytes_next;
    pkt_t                inj_reg,         inj_next;
    logic [BANK_W-1:0]   bank_reg,        bank_next;
    logic                kind_reg,        kind_next;
    logic [PROD_W-1:0]   prod_reg,        prod_next;

    logic [SLOT_W-1:0]   res_slot_reg,    res_slot_next;
    logic                res_hit_reg,     res_hit_next;
    logic                res_load_reg,    res_load_next;
    logic                res_kind_reg,    res_kind_next;
    logic [OFFSET_W-1:0] res_offset_reg,  res_offset_next;
    logic [BANK_W-1:0]   res_stored_reg,  res_stored_next;

    logic                m_valid_reg,     m_valid_next;
    logic [SLOT_W-1:0]   m_slot_reg,      m_slot_next;
    logic                m_hit_reg,       m_hit_next;
    logic                m_load_reg,      m_load_next;
    logic                m_kind_reg,      m_kind_next;
    logic [OFFSET_W-1:0] m_offset_reg,    m_offset_next;
    logic [BANK_W-1:0]   m_stored_reg,    m_stored_next;

    pkt_t                chain [NUM_SLOTS+1];
    logic [BANK_W-1:0]   tags  [NUM_SLOTS];
    upd_t                upd;
    pkt_t                done_pkt;
    slot_idx_t           pick_idx;
    logic                accept;

    assign chain[0] = inj_reg;
    assign done_pkt = chain[NUM_SLOTS];

    for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
        lbsc_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .cell_idx (SLOT_IDX_W'(i)),
            .pkt_in   (chain[i]),
            .upd      (upd),
            .pkt_out  (chain[i+1]),
            .tag      (tags[i])
        );
    end

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign pick_idx = done_pkt.found ? done_pkt.found_idx : done_pkt.min_idx;

    always_comb begin
        state_next      = state_reg;
        tick_next       = tick_reg;
        bank_bytes_next = bank_bytes_reg;
        inj_next        = '0;
        bank_next       = bank_reg;
        kind_next       = kind_reg;
        prod_next       = prod_reg;
        res_slot_next   = res_slot_reg;
        res_hit_next    = res_hit_reg;
        res_load_next   = res_load_reg;
        res_kind_next   = res_kind_reg;
        res_offset_next = res_offset_reg;
        res_stored_next = res_stored_reg;
        m_valid_next    = m_valid_reg;
        m_slot_next     = m_slot_reg;
        m_hit_next      = m_hit_reg;
        m_load_next     = m_load_reg;
        m_kind_next     = m_kind_reg;
        m_offset_next   = m_offset_reg;
        m_stored_next   = m_stored_reg;
        upd             = '0;

        if (cfg_wr_en) begin
            bank_bytes_next = cfg_wr_data;
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    res_slot_next   = '0;
                    res_hit_next    = 1'b0;
                    res_load_next   = 1'b0;
                    res_kind_next   = 1'b0;
                    res_offset_next = '0;
                    res_stored_next = '0;
                    state_next      = ST_RESULT;
                    unique case (mode_t'(s_mode))
                        MODE_LOOKUP: begin
                            tick_next      = tick_reg + 1'b1;
                            inj_next.valid = 1'b1;
                            inj_next.bank  = s_bank_number;
                            bank_next      = s_bank_number;
                            kind_next      = s_rom_kind;
                            prod_next      = PROD_W'(s_bank_number) * PROD_W'(bank_bytes_reg);
                            state_next     = ST_SEARCH;
                        end
                        MODE_CLEAR: begin
                            upd.clr   = 1'b1;
                            tick_next = '0;
                        end
                        MODE_QUERY: begin
                            if (32'(s_slot_query) < NUM_SLOTS) begin
                                res_stored_next = tags[SLOT_IDX_W'(s_slot_query)];
                            end
                        end
                        MODE_UNUSED: begin
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SEARCH: begin
                if (done_pkt.valid) begin
                    upd.wr        = 1'b1;
                    upd.idx       = pick_idx;
                    upd.tag       = bank_reg;
                    upd.stamp     = tick_reg;
                    res_slot_next = SLOT_W'(pick_idx);
                    res_hit_next  = done_pkt.found;
                    res_load_next = !done_pkt.found;
                    res_kind_next = done_pkt.found ? 1'b0 : kind_reg;
                    if (done_pkt.found) begin
                        res_offset_next = '0;
                    end else if (prod_reg > PROD_W'(OFFSET_MAX)) begin
                        res_offset_next = OFFSET_MAX;
                    end else begin
                        res_offset_next = prod_reg[OFFSET_W-1:0];
                    end
                    res_stored_next = '0;
                    state_next      = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_slot_next   = res_slot_reg;
                    m_hit_next    = res_hit_reg;
                    m_load_next   = res_load_reg;
                    m_kind_next   = res_kind_reg;
                    m_offset_next = res_offset_reg;
                    m_stored_next = res_stored_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            tick_reg       <= '0;
            bank_bytes_reg <= BANK_BYTES_RESET;
            inj_reg        <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            tick_reg       <= tick_next;
            bank_bytes_reg <= bank_bytes_next;
            inj_reg        <= inj_next;
            m_valid_reg    <= m_valid_next;
        end
        bank_reg       <= bank_next;
        kind_reg       <= kind_next;
        prod_reg       <= prod_next;
        res_slot_reg   <= res_slot_next;
        res_hit_reg    <= res_hit_next;
        res_load_reg   <= res_load_next;
        res_kind_reg   <= res_kind_next;
        res_offset_reg <= res_offset_next;
        res_stored_reg <= res_stored_next;
        m_slot_reg     <= m_slot_next;
        m_hit_reg      <= m_hit_next;
        m_load_reg     <= m_load_next;
        m_kind_reg     <= m_kind_next;
        m_offset_reg   <= m_offset_next;
        m_stored_reg   <= m_stored_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_slot        = m_slot_reg;
    assign m_hit         = m_hit_reg;
    assign m_load_needed = m_load_reg;
    assign m_load_kind   = m_kind_reg;
    assign m_load_offset = m_offset_reg;
    assign m_stored_bank = m_stored_reg;

endmodule

>>> design/lbsc_checker.sv
// Port-level checks for the LRU bank slot cache, bound to the top level.
module lbsc_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_valid,
    input logic                               s_ready,
    input logic                               m_valid,
    input logic                               m_ready,
    input logic [lbsc_pkg::SLOT_W-1:0]        m_slot,
    input logic                               m_hit,
    input logic                               m_load_needed,
    input logic                               m_load_kind,
    input logic [lbsc_pkg::OFFSET_W-1:0]      m_load_offset,
    input logic [lbsc_pkg::BANK_W-1:0]        m_stored_bank
);
    import lbsc_pkg::*;

    // a hit and a miss load are exclusive
    a_hit_xor_load: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_hit && m_load_needed))
        else $error("hit and load_needed both set");

    // one transaction at a time
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted on consecutive cycles");

    // load fields only on a miss, stored tag never alongside a load
    a_load_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_load_needed) |-> (m_load_offset == '0) && !m_load_kind)
        else $error("load fields set without a miss");

    a_miss_no_tag: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_load_needed || m_hit)) |-> (m_stored_bank == '0))
        else $error("stored_bank set on a lookup result");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid && $stable(m_slot) && $stable(m_load_offset))
        else $error("stalled result changed");

endmodule

bind lru_bank_slot_cache lbsc_checker u_lbsc_checker (.*);

>>> dv/tb.sv
// Testbench for the LRU bank slot cache: scoreboard class, request and result drivers.
module tb;
    import lbsc_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        mode_t               mode;
        logic [BANK_W-1:0]   bank;
        logic                kind;
        logic [SLOT_W-1:0]   query;
    } cache_req_t;

    typedef struct packed {
        logic [SLOT_W-1:0]   slot;
        logic                hit;
        logic                load_needed;
        logic                load_kind;
        logic [OFFSET_W-1:0] load_offset;
        logic [BANK_W-1:0]   stored_bank;
    } cache_res_t;

    class slot_cache_scoreboard;
        logic [BANK_W-1:0]  tags[NUM_SLOTS];
        logic [STAMP_W-1:0] stamps[NUM_SLOTS];
        logic [STAMP_W-1:0] tick;
        logic [BYTES_W-1:0] bank_bytes;
        cache_res_t         expected_q[$];
        int                 errors;

        function new();
            errors     = 0;
            bank_bytes = BANK_BYTES_RESET;
            clear_slots();
        endfunction

        function void clear_slots();
            tick = '0;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                tags[i]   = EMPTY_TAG;
                stamps[i] = '0;
            end
        endfunction

        function void set_bank_bytes(logic [BYTES_W-1:0] v);
            bank_bytes = v;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endfunction

        function void note_request(cache_req_t r);
            cache_res_t         res;
            int                 found;
            int                 victim;
            logic [STAMP_W-1:0] least;
            logic [PROD_W-1:0]  prod;
            res = '0;
            if (r.mode == MODE_LOOKUP) begin
                tick  = tick + 1;
                found = -1;
                for (int i = 0; i < NUM_SLOTS; i++)
                    if (found < 0 && tags[i] == r.bank) found = i;
                if (found >= 0) begin
                    stamps[found] = tick;
                    res.slot      = found[SLOT_W-1:0];
                    res.hit       = 1'b1;
                end else begin
                    victim = 0;
                    least  = stamps[0];
                    for (int i = 1; i < NUM_SLOTS; i++) begin
                        if (stamps[i] < least) begin
                            least  = stamps[i];
                            victim = i;
                        end
                    end
                    prod = PROD_W'(r.bank) * PROD_W'(bank_bytes);
                    tags[victim]    = r.bank;
                    stamps[victim]  = tick;
                    res.slot        = victim[SLOT_W-1:0];
                    res.load_needed = 1'b1;
                    res.load_kind   = r.kind;
                    res.load_offset = (prod > OFFSET_MAX) ? OFFSET_MAX : prod[OFFSET_W-1:0];
                end
            end else if (r.mode == MODE_CLEAR) begin
                clear_slots();
            end else if (r.mode == MODE_QUERY) begin
                if (r.query < NUM_SLOTS) res.stored_bank = tags[r.query];
            end
            expected_q.push_back(res);
        endfunction

        function void compare_field(string name, int got, int want);
            if (got != want)
                report($sformatf("%s got %0d expected %0d", name, got, want));
        endfunction

        function void check_result(cache_res_t got);
            cache_res_t want;
            if (expected_q.size() == 0) begin
                report("result transaction with no request outstanding");
                return;
            end
            want = expected_q.pop_front();
            compare_field("slot", got.slot, want.slot);
            compare_field("hit", got.hit, want.hit);
            compare_field("load_needed", got.load_needed, want.load_needed);
            compare_field("load_kind", got.load_kind, want.load_kind);
            compare_field("load_offset", got.load_offset, want.load_offset);
            compare_field("stored_bank", got.stored_bank, want.stored_bank);
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [BYTES_W-1:0]    cfg_wr_data;
    logic                  s_valid;
    logic                  s_ready;
    logic [MODE_W-1:0]     s_mode;
    logic [BANK_W-1:0]     s_bank_number;
    logic                  s_rom_kind;
    logic [SLOT_W-1:0]     s_slot_query;
    logic                  m_valid;
    logic                  m_ready;
    logic [SLOT_W-1:0]     m_slot;
    logic                  m_hit;
    logic                  m_load_needed;
    logic                  m_load_kind;
    logic [OFFSET_W-1:0]   m_load_offset;
    logic [BANK_W-1:0]     m_stored_bank;

    slot_cache_scoreboard  sb;
    int                    snd_idle_pct;
    int                    rcv_stall_pct;
    bit                    hold_req;
    int                    cycle_count = 0;

    lru_bank_slot_cache dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mode        (s_mode),
        .s_bank_number (s_bank_number),
        .s_rom_kind    (s_rom_kind),
        .s_slot_query  (s_slot_query),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_slot        (m_slot),
        .m_hit         (m_hit),
        .m_load_needed (m_load_needed),
        .m_load_kind   (m_load_kind),
        .m_load_offset (m_load_offset),
        .m_stored_bank (m_stored_bank)
    );

    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb failed");
            $finish;
        end
    end

    // result side: check accepted transactions, then pick next m_ready
    initial begin
        int hold_left;
        hold_left = 0;
        m_ready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready)
                sb.check_result({m_slot, m_hit, m_load_needed, m_load_kind,
                                 m_load_offset, m_stored_bank});
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= rcv_stall_pct);
            end
        end
    end

    function automatic cache_req_t make_req(mode_t m, int bank, bit kind, int q);
        cache_req_t r;
        r.mode  = m;
        r.bank  = bank[BANK_W-1:0];
        r.kind  = kind;
        r.query = q[SLOT_W-1:0];
        return r;
    endfunction

    function automatic cache_req_t random_request();
        cache_req_t r;
        int pick;
        int p;
        r.bank  = BANK_W'($urandom_range(255));
        r.kind  = 1'($urandom_range(1));
        r.query = SLOT_W'($urandom_range(7));
        pick    = $urandom_range(99);
        if (pick < 4) begin
            r.mode = MODE_CLEAR;
        end else if (pick < 7) begin
            r.mode = MODE_UNUSED;
        end else if (pick < 22) begin
            r.mode = MODE_QUERY;
        end else begin
            r.mode = MODE_LOOKUP;
            // small working set a little larger than the cache, so hits and evictions mix
            if ($urandom_range(99) < 80) begin
                p = $urandom_range(11);
                r.bank = (p == 11) ? EMPTY_TAG : p[BANK_W-1:0];
            end
        end
        return r;
    endfunction

    task automatic send_request(cache_req_t r);
        while (snd_idle_pct > 0 && $urandom_range(99) < snd_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_mode        <= r.mode;
        s_bank_number <= r.bank;
        s_rom_kind    <= r.kind;
        s_slot_query  <= r.query;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(r);
    endtask

    task automatic wait_drained();
        do @(posedge aclk); while (sb.pending() != 0);
    endtask

    task automatic write_bank_bytes(logic [BYTES_W-1:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        sb.set_bank_bytes(v);
    endtask

    task automatic run_phase(int n, int snd, int rcv, bit hold, bit pause);
        snd_idle_pct  = snd;
        rcv_stall_pct = rcv;
        if (hold) hold_req = 1'b1;
        for (int i = 0; i < n; i++) begin
            if (pause && i == n / 2) begin
                s_valid <= 1'b0;
                wait_drained();
            end
            send_request(random_request());
        end
        s_valid <= 1'b0;
        wait_drained();
    endtask

    initial begin
        cache_req_t directed[$];
        sb            = new();
        snd_idle_pct  = 0;
        rcv_stall_pct = 0;
        hold_req      = 1'b0;
        aresetn       <= 1'b0;
        cfg_wr_en     <= 1'b0;
        cfg_wr_data   <= '0;
        s_valid       <= 1'b0;
        s_mode        <= MODE_LOOKUP;
        s_bank_number <= '0;
        s_rom_kind    <= 1'b0;
        s_slot_query  <= '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // bank 255 matches an empty slot, then fill, hit, evict, read back
        directed.push_back(make_req(MODE_LOOKUP, 255, 1'b0, 0));
        directed.push_back(make_req(MODE_LOOKUP, 0, 1'b1, 7));
        for (int b = 1; b <= 6; b++)
            directed.push_back(make_req(MODE_LOOKUP, b, 1'(b % 2), 0));
        directed.push_back(make_req(MODE_LOOKUP, 254, 1'b1, 0));
        directed.push_back(make_req(MODE_LOOKUP, 0, 1'b0, 0));
        directed.push_back(make_req(MODE_LOOKUP, 200, 1'b1, 0));
        for (int q = 0; q < NUM_SLOTS; q++)
            directed.push_back(make_req(MODE_QUERY, 255 - q, 1'(q % 2), q));
        directed.push_back(make_req(MODE_UNUSED, 255, 1'b1, 7));
        directed.push_back(make_req(MODE_CLEAR, 170, 1'b1, 5));
        directed.push_back(make_req(MODE_QUERY, 0, 1'b0, 3));
        directed.push_back(make_req(MODE_LOOKUP, 255, 1'b1, 0));
        directed.push_back(make_req(MODE_LOOKUP, 128, 1'b1, 2));
        foreach (directed[i]) send_request(directed[i]);
        s_valid <= 1'b0;
        wait_drained();

        write_bank_bytes(16'd1);
        run_phase(300, 0, 0, 1'b0, 1'b0);
        write_bank_bytes(16'd32768);
        run_phase(320, 62, 0, 1'b0, 1'b1);
        write_bank_bytes(16'hFFFF);
        run_phase(320, 0, 62, 1'b1, 1'b0);
        write_bank_bytes(16'd0);
        run_phase(320, 10, 10, 1'b0, 1'b0);
        write_bank_bytes(BYTES_W'($urandom_range(32768, 1)));
        run_phase(320, 0, 0, 1'b1, 1'b0);
        write_bank_bytes(BYTES_W'($urandom_range(65535)));
        run_phase(320, 62, 62, 1'b0, 1'b1);

        repeat (20) @(posedge aclk);
        if (sb.pending() != 0) sb.report("requests left without a result");
        if (sb.errors == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
